// File: design/rmlps_pkg.sv
// Package for the rate-monotonic laxity promotion scheduler.
// Holds sizes, opcodes, status codes, controller state type and control structs; no dependencies.
`default_nettype none
package rmlps_pkg;
   localparam int MaxTasks  = 8;
   localparam int TimeBits  = 16;
   localparam int SlotBits  = $clog2(MaxTasks);
   localparam int CountBits = 4;
   localparam logic [TimeBits-1:0] TimeMax = '1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FAIL = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RESULT
   } ctrl_state_type;

   typedef struct packed {
      logic do_load;
      logic do_tick;
   } dp_cmd_type;
endpackage
`default_nettype wire

// File: design/rmlps_ctrl.sv
// Controller for the scheduler: accepts request beats, issues datapath commands,
// holds the response handshake. Depends on rmlps_pkg.
`default_nettype none
module rmlps_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_op,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rmlps_pkg::dp_cmd_type      cmd
);
   import rmlps_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           accept;

   // Take a new beat when no response waits, or the waiting one leaves now.
   assign req_ready = (state_ff == ST_IDLE) || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_TICK) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_ready) begin
               if (accept && req_op == OP_TICK) state_in = ST_RESULT;
               else state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid   = (state_ff == ST_RESULT);
      cmd.do_load = accept && (req_op == OP_LOAD);
      cmd.do_tick = accept && (req_op == OP_TICK);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

// File: design/rmlps_dp.sv
// Datapath for the scheduler: task tables, time, promotion state, selection and
// the response register. Depends on rmlps_pkg.
`default_nettype none
module rmlps_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rmlps_pkg::dp_cmd_type          cmd,
   input  wire logic [rmlps_pkg::CountBits-1:0] task_count,
   input  wire logic [2:0]                     task_index,
   input  wire logic [15:0]                    task_period,
   input  wire logic [15:0]                    task_exec,
   output logic [3:0]                          running_task,
   output logic                                promoted,
   output logic [15:0]                         instance_number,
   output logic [15:0]                         release_time,
   output logic [15:0]                         job_deadline,
   output logic [15:0]                         work_left,
   output logic [1:0]                          status
);
   import rmlps_pkg::*;

   logic [TimeBits-1:0] period_ff   [MaxTasks];
   logic [TimeBits-1:0] exec_ff     [MaxTasks];
   logic [TimeBits-1:0] release_ff  [MaxTasks];
   logic [TimeBits-1:0] deadline_ff [MaxTasks];
   logic [TimeBits-1:0] left_ff     [MaxTasks];
   logic [15:0]         inst_ff     [MaxTasks];
   logic [TimeBits-1:0] now_ff;
   logic                prom_on_ff;
   logic [SlotBits-1:0] prom_slot_ff;
   logic                failed_ff;

   logic [MaxTasks-1:0] in_use, ready, zero_lax;
   logic                saturated, keep_prom, have_zero, multi_zero, other_zero;
   logic                have_norm, have, prom;
   logic [SlotBits-1:0] zero_pick, norm_pick, pick;
   logic [TimeBits:0]   lax_sum [MaxTasks];

   // Flag per slot: in use, ready, zero laxity (deadline == now + left).
   always_comb begin
      for (int i = 0; i < MaxTasks; i++) begin
         in_use[i]   = ({1'b0, task_count} > (CountBits+1)'(i));
         ready[i]    = in_use[i] && (release_ff[i] <= now_ff) && (left_ff[i] != '0);
         lax_sum[i]  = {1'b0, now_ff} + {1'b0, left_ff[i]};
         zero_lax[i] = ready[i] && (lax_sum[i] == {1'b0, deadline_ff[i]});
      end
   end

   // Rank pick: shortest period, then lowest slot.
   always_comb begin
      have_zero  = 1'b0;
      multi_zero = 1'b0;
      zero_pick  = '0;
      have_norm  = 1'b0;
      norm_pick  = '0;
      for (int i = 0; i < MaxTasks; i++) begin
         if (zero_lax[i]) begin
            if (have_zero) multi_zero = 1'b1;
            if (!have_zero || period_ff[i] < period_ff[zero_pick])
               zero_pick = SlotBits'(i);
            have_zero = 1'b1;
         end
         if (ready[i]) begin
            if (!have_norm || period_ff[i] < period_ff[norm_pick])
               norm_pick = SlotBits'(i);
            have_norm = 1'b1;
         end
      end
   end

   always_comb begin
      saturated  = (now_ff == TimeMax);
      keep_prom  = prom_on_ff && ready[prom_slot_ff];
      other_zero = |(zero_lax & ~(MaxTasks'(1) << prom_slot_ff));
      if (keep_prom) begin
         pick = prom_slot_ff;
         have = 1'b1;
         prom = 1'b1;
      end else if (have_zero) begin
         pick = zero_pick;
         have = 1'b1;
         prom = 1'b1;
      end else begin
         pick = norm_pick;
         have = have_norm;
         prom = 1'b0;
      end
   end

   logic [TimeBits-1:0] left_dec;
   logic                finish;
   logic [TimeBits:0]   rel_sum, dl_sum;
   logic [TimeBits-1:0] rel_next, dl_next;
   logic                fail_next;

   always_comb begin
      left_dec  = left_ff[pick] - 1'b1;
      finish    = (left_dec == '0);
      rel_sum   = {1'b0, release_ff[pick]} + {1'b0, period_ff[pick]};
      dl_sum    = {1'b0, deadline_ff[pick]} + {1'b0, period_ff[pick]};
      rel_next  = rel_sum[TimeBits] ? TimeMax : rel_sum[TimeBits-1:0];
      dl_next   = dl_sum[TimeBits] ? TimeMax : dl_sum[TimeBits-1:0];
      fail_next = failed_ff || (keep_prom ? other_zero : multi_zero);
   end

   // Table and control state updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MaxTasks; i++) begin
            release_ff[i]  <= '0;
            deadline_ff[i] <= '0;
            left_ff[i]     <= '0;
            inst_ff[i]     <= 16'd1;
         end
         now_ff       <= '0;
         prom_on_ff   <= 1'b0;
         prom_slot_ff <= '0;
         failed_ff    <= 1'b0;
      end else if (cmd.do_load) begin
         period_ff[task_index]   <= task_period;
         exec_ff[task_index]     <= task_exec;
         release_ff[task_index]  <= '0;
         deadline_ff[task_index] <= task_period;
         left_ff[task_index]     <= task_exec;
         inst_ff[task_index]     <= 16'd1;
         if (prom_slot_ff == task_index) prom_on_ff <= 1'b0;
      end else if (cmd.do_tick && !saturated) begin
         now_ff       <= now_ff + 1'b1;
         failed_ff    <= fail_next;
         prom_on_ff   <= prom && !finish;
         prom_slot_ff <= prom ? pick : prom_slot_ff;
         if (have) begin
            if (finish) begin
               inst_ff[pick]     <= inst_ff[pick] + 1'b1;
               release_ff[pick]  <= rel_next;
               deadline_ff[pick] <= dl_next;
               left_ff[pick]     <= exec_ff[pick];
            end else begin
               left_ff[pick] <= left_dec;
            end
         end
      end
   end

   // Response register; loaded on every tick beat.
   always_ff @(posedge clock) begin
      if (cmd.do_tick) begin
         if (saturated || !have) begin
            running_task    <= '0;
            promoted        <= 1'b0;
            instance_number <= '0;
            release_time    <= '0;
            job_deadline    <= '0;
            work_left       <= '0;
            status          <= saturated ? STATUS_SAT : (fail_next ? STATUS_FAIL : STATUS_OK);
         end else begin
            running_task    <= 4'(pick) + 4'd1;
            promoted        <= prom;
            instance_number <= inst_ff[pick];
            release_time    <= release_ff[pick];
            job_deadline    <= deadline_ff[pick];
            work_left       <= left_dec;
            status          <= fail_next ? STATUS_FAIL : STATUS_OK;
         end
      end
   end
endmodule
`default_nettype wire

// File: design/rm_laxity_promotion_scheduler.sv
// Rate-monotonic scheduler with laxity promotion, one time unit per tick beat.
// Latency: a tick's response is valid the cycle after the request beat; a load gives none.
// Throughput: one request beat per cycle; while a response waits, only as it leaves.
// All laxity compares and the rank pick over eight slots are combinational in the datapath.
// Reset (synchronous, active high) clears time, promotion, failure, job tables; count = 1.
`default_nettype none
module rm_laxity_promotion_scheduler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [2:0]  req_task_index,
   input  wire logic [15:0] req_task_period,
   input  wire logic [15:0] req_task_exec,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_running_task,
   output logic             rsp_promoted,
   output logic [15:0]      rsp_instance_number,
   output logic [15:0]      rsp_release_time,
   output logic [15:0]      rsp_job_deadline,
   output logic [15:0]      rsp_work_left,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_write,
   input  wire logic [3:0]  csr_wdata
);
   import rmlps_pkg::*;

   dp_cmd_type           cmd;
   logic [CountBits-1:0] count_ff;

   // Hold the slot count; cap above MaxTasks is implied by the slot compare.
   always_ff @(posedge clock) begin
      if (reset) count_ff <= CountBits'(1);
      else if (csr_write) count_ff <= csr_wdata;
   end

   rmlps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   rmlps_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .task_count      (count_ff),
      .task_index      (req_task_index),
      .task_period     (req_task_period),
      .task_exec       (req_task_exec),
      .running_task    (rsp_running_task),
      .promoted        (rsp_promoted),
      .instance_number (rsp_instance_number),
      .release_time    (rsp_release_time),
      .job_deadline    (rsp_job_deadline),
      .work_left       (rsp_work_left),
      .status          (rsp_status)
   );
endmodule
`default_nettype wire
